// ----- rtl/core/pms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pms_pkg: shared types and constants of the Potts site-flip engine
// Field widths, register codes, the stage-to-stage payload structs and the
// exp(-E) lookup table used by the acceptance stage.
// ----------------------------------------------------------------------------
package pms_pkg;

  // Stream payload widths (fields packed from bit 0 up, padded to bytes).
  localparam int IN_W  = 120;
  localparam int OUT_W = 40;

  // APB register space: four 32-bit registers at byte offsets 0, 4, 8, 12.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Grain ids are compared on this many bits.
  localparam int GRAIN_BITS = 16;
  localparam int GRAIN_W    = (GRAIN_BITS < 16) ? GRAIN_BITS : 16;

  // Datapath widths.
  localparam int CONC_W   = 16;
  localparam int COEF_W   = 15;
  localparam int COMP_W   = 13;
  localparam int CDIFF_W  = 14;
  localparam int SUM_W    = 18;
  localparam int PROD1_W  = 32;
  localparam int PROD2_W  = 48;
  localparam int ROUND_SH = 24;
  localparam int WELL_W   = PROD2_W - ROUND_SH;
  localparam int BTERM_W  = 20;
  localparam int TOTAL_W  = 26;
  localparam int DRAW_W   = 16;

  // Exp table: entry i holds exp(-i/32) in Q16. A saturated 16-bit change
  // never indexes past entry 255, so that is all the table needs to hold.
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_ROM_ENTRIES = 256;
  localparam int EXP_IDX_W       = 8;
  localparam int EXP_VAL_W       = 17;
  localparam logic [31:0] EXP_STEP_Q32 = 32'd4162825044;

  // Register codes (word index inside the APB space).
  typedef enum logic [1:0] {
    REG_WELL_WEIGHT = 2'd0,
    REG_ALPHA_COMP  = 2'd1,
    REG_BETA_COMP   = 2'd2,
    REG_BOND_ENERGY = 2'd3
  } reg_idx_e;

  // Neighbour pick codes.
  typedef enum logic [1:0] {
    PICK_EAST  = 2'd0,
    PICK_WEST  = 2'd1,
    PICK_NORTH = 2'd2,
    PICK_SOUTH = 2'd3
  } pick_e;

  // Configuration register file contents.
  typedef struct packed {
    logic [COEF_W-1:0] well_weight;
    logic [COMP_W-1:0] alpha_comp;
    logic [COMP_W-1:0] beta_comp;
    logic [COEF_W-1:0] bond_energy;
  } cfg_t;

  // One lattice site as it arrives on the input stream.
  typedef struct packed {
    logic signed [CONC_W-1:0] concentration;
    logic [4:0]               phase_bits;
    logic [GRAIN_W-1:0]       center_grain;
    logic [GRAIN_W-1:0]       east_grain;
    logic [GRAIN_W-1:0]       west_grain;
    logic [GRAIN_W-1:0]       north_grain;
    logic [GRAIN_W-1:0]       south_grain;
    pick_e                    neighbour_pick;
    logic [DRAW_W-1:0]        uniform_draw;
  } site_t;

  // State of the site and of the candidate, carried down the pipeline.
  typedef struct packed {
    logic               phase_center;
    logic               phase_pick;
    logic [GRAIN_W-1:0] grain_center;
    logic [GRAIN_W-1:0] grain_pick;
    logic [DRAW_W-1:0]  draw;
  } carry_t;

  // Output of the front stage.
  typedef struct packed {
    logic signed [SUM_W-1:0]   comp_sum;
    logic signed [CDIFF_W-1:0] comp_diff;
    logic signed [3:0]         bond_delta;
    logic signed [1:0]         dphi;
    carry_t                    carry;
  } front_t;

  // Output of the energy pipeline.
  typedef struct packed {
    logic signed [15:0] energy;
    carry_t             carry;
  } energy_t;

  // One result item.
  typedef struct packed {
    logic               new_phase;
    logic [GRAIN_W-1:0] new_grain;
    logic               flipped;
    logic signed [15:0] energy_change;
  } result_t;

  typedef logic [EXP_ROM_ENTRIES-1:0][EXP_VAL_W-1:0] exp_rom_t;

  // Builds the table by repeated multiplication with exp(-1/32) in Q32,
  // then rounds each Q32 value to Q16.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [95:0] t;
    t = 96'd1 << 32;
    for (int i = 0; i < EXP_ROM_ENTRIES; i++) begin
      if (i > 0) begin
        t = (t * {64'd0, EXP_STEP_Q32}) >> 32;
      end
      rom[i] = EXP_VAL_W'((t + 96'd32768) >> 16);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage
`default_nettype wire

// ----- rtl/core/pms_site_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pms_site_stage: first pipeline stage
// Counts unlike grain neighbours for the site and for the candidate, selects
// the candidate's state and forms the composition difference and sum used by
// the well term.
// ----------------------------------------------------------------------------
module pms_site_stage (
  input  wire  logic            clk_i,
  input  wire  logic            rst_ni,
  input  wire  pms_pkg::cfg_t   cfg_i,
  input  wire  logic            in_valid_i,
  output logic                  in_ready_o,
  input  wire  pms_pkg::site_t  site_i,
  output logic                  out_valid_o,
  input  wire  logic            out_ready_i,
  output pms_pkg::front_t       out_o
);

  logic            valid_q;
  pms_pkg::front_t front_d;
  pms_pkg::front_t front_q;

  logic [pms_pkg::GRAIN_W-1:0] nbr_grain [4];
  logic [3:0]                  nbr_phase;
  logic [pms_pkg::GRAIN_W-1:0] grain_pick;
  logic                        phase_pick;
  logic [2:0]                  unlike_center;
  logic [2:0]                  unlike_pick;
  logic signed [pms_pkg::SUM_W-1:0] conc_x2;

  // Candidate selection and unlike-neighbour counts.
  always_comb begin
    nbr_grain[0] = site_i.east_grain;
    nbr_grain[1] = site_i.west_grain;
    nbr_grain[2] = site_i.north_grain;
    nbr_grain[3] = site_i.south_grain;
    nbr_phase    = site_i.phase_bits[4:1];

    unique case (site_i.neighbour_pick)
      pms_pkg::PICK_EAST:  grain_pick = nbr_grain[0];
      pms_pkg::PICK_WEST:  grain_pick = nbr_grain[1];
      pms_pkg::PICK_NORTH: grain_pick = nbr_grain[2];
      pms_pkg::PICK_SOUTH: grain_pick = nbr_grain[3];
      default:             grain_pick = nbr_grain[0];
    endcase
    phase_pick = nbr_phase[site_i.neighbour_pick];

    unlike_center = 3'd0;
    unlike_pick   = 3'd0;
    for (int k = 0; k < 4; k++) begin
      unlike_center = unlike_center + 3'(nbr_grain[k] != site_i.center_grain);
      unlike_pick   = unlike_pick + 3'(nbr_grain[k] != grain_pick);
    end
  end

  // Well term factors: (C3 - C4) and (2c - C3 - C4).
  always_comb begin
    conc_x2 = {site_i.concentration[pms_pkg::CONC_W-1], site_i.concentration, 1'b0};
    front_d.comp_sum = conc_x2
                     - $signed({5'd0, cfg_i.alpha_comp})
                     - $signed({5'd0, cfg_i.beta_comp});
    front_d.comp_diff = $signed({1'b0, cfg_i.alpha_comp})
                      - $signed({1'b0, cfg_i.beta_comp});
    front_d.bond_delta = $signed({1'b0, unlike_pick}) - $signed({1'b0, unlike_center});
    front_d.dphi = $signed({1'b0, phase_pick}) - $signed({1'b0, site_i.phase_bits[0]});
    front_d.carry.phase_center = site_i.phase_bits[0];
    front_d.carry.phase_pick   = phase_pick;
    front_d.carry.grain_center = site_i.center_grain;
    front_d.carry.grain_pick   = grain_pick;
    front_d.carry.draw         = site_i.uniform_draw;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      front_q <= front_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = front_q;

endmodule
`default_nettype wire

// ----- rtl/core/pms_energy_pipe.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pms_energy_pipe: energy change pipeline
// Three stages: composition product and bond term, multiplication by the
// well weight, then rounding to Q12, phase sign, sum and saturation.
// ----------------------------------------------------------------------------
module pms_energy_pipe (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  pms_pkg::cfg_t    cfg_i,
  input  wire  logic             in_valid_i,
  output logic                   in_ready_o,
  input  wire  pms_pkg::front_t  in_i,
  output logic                   out_valid_o,
  input  wire  logic             out_ready_i,
  output pms_pkg::energy_t       out_o
);

  localparam int PW = pms_pkg::PROD2_W;
  localparam int TW = pms_pkg::TOTAL_W;
  localparam logic signed [PW-1:0] ROUND_BIAS = PW'(1) <<< (pms_pkg::ROUND_SH - 1);
  localparam logic signed [TW-1:0] SAT_MAX    = TW'(32767);
  localparam logic signed [TW-1:0] SAT_MIN    = -TW'(32768);

  typedef struct packed {
    logic signed [pms_pkg::PROD1_W-1:0] prod;
    logic signed [pms_pkg::BTERM_W-1:0] bterm;
    logic signed [1:0]                  dphi;
    pms_pkg::carry_t                    carry;
  } mul1_t;

  typedef struct packed {
    logic signed [PW-1:0]               prod;
    logic signed [pms_pkg::BTERM_W-1:0] bterm;
    logic signed [1:0]                  dphi;
    pms_pkg::carry_t                    carry;
  } mul2_t;

  logic             v2_q, v3_q, v4_q;
  logic             rdy2, rdy3, rdy4;
  mul1_t            s2_d, s2_q;
  mul2_t            s3_d, s3_q;
  pms_pkg::energy_t s4_d, s4_q;

  logic signed [PW-1:0]                  round_sum;
  logic signed [pms_pkg::WELL_W-1:0]     well;
  logic signed [TW-1:0]                  well_term;
  logic signed [TW-1:0]                  total;

  // Stage 2: (C3 - C4) * (2c - C3 - C4) and bond delta times bond energy.
  always_comb begin
    s2_d.prod  = in_i.comp_diff * in_i.comp_sum;
    s2_d.bterm = in_i.bond_delta * $signed({1'b0, cfg_i.bond_energy});
    s2_d.dphi  = in_i.dphi;
    s2_d.carry = in_i.carry;
  end

  // Stage 3: scale by the well weight.
  always_comb begin
    s3_d.prod  = s2_q.prod * $signed({1'b0, cfg_i.well_weight});
    s3_d.bterm = s2_q.bterm;
    s3_d.dphi  = s2_q.dphi;
    s3_d.carry = s2_q.carry;
  end

  // Stage 4: round half up to Q12, apply the phase difference, add, saturate.
  always_comb begin
    round_sum = s3_q.prod + ROUND_BIAS;
    well      = round_sum[PW-1:pms_pkg::ROUND_SH];
    priority if (s3_q.dphi == 2'sd1) begin
      well_term = {{(TW - pms_pkg::WELL_W){well[pms_pkg::WELL_W-1]}}, well};
    end else if (s3_q.dphi == -2'sd1) begin
      well_term = -{{(TW - pms_pkg::WELL_W){well[pms_pkg::WELL_W-1]}}, well};
    end else begin
      well_term = '0;
    end
    total = well_term
          + {{(TW - pms_pkg::BTERM_W){s3_q.bterm[pms_pkg::BTERM_W-1]}}, s3_q.bterm};
    priority if (total > SAT_MAX) begin
      s4_d.energy = 16'sh7fff;
    end else if (total < SAT_MIN) begin
      s4_d.energy = -16'sh8000;
    end else begin
      s4_d.energy = total[15:0];
    end
    s4_d.carry = s3_q.carry;
  end

  // Per-stage ready: a stage takes new data when empty or when it drains.
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy2) begin
      s2_q <= s2_d;
    end
    if (v2_q && rdy3) begin
      s3_q <= s3_d;
    end
    if (v3_q && rdy4) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_o       = s4_q;

endmodule
`default_nettype wire

// ----- rtl/core/pms_accept_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pms_accept_stage: Metropolis decision and output register
// A negative change always flips; otherwise the draw is compared with the
// exp(-E) table entry selected by the change.
// ----------------------------------------------------------------------------
module pms_accept_stage (
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  logic              in_valid_i,
  output logic                    in_ready_o,
  input  wire  pms_pkg::energy_t  in_i,
  output logic                    out_valid_o,
  input  wire  logic              out_ready_i,
  output pms_pkg::result_t        out_o
);

  logic                              valid_q;
  pms_pkg::result_t                  res_d;
  pms_pkg::result_t                  res_q;
  logic [pms_pkg::EXP_IDX_W-1:0]     exp_idx;
  logic [pms_pkg::EXP_VAL_W-1:0]     exp_val;
  logic                              idx_ok;
  logic                              flip;

  // Table lookup and acceptance.
  always_comb begin
    exp_idx = in_i.energy[14:7];
    exp_val = pms_pkg::EXP_ROM[exp_idx];
    idx_ok  = 32'(exp_idx) < pms_pkg::EXP_TABLE_DEPTH;
    flip    = in_i.energy[15]
           || (idx_ok && ({1'b0, in_i.carry.draw} < exp_val));
    res_d.flipped       = flip;
    res_d.energy_change = in_i.energy;
    res_d.new_phase     = flip ? in_i.carry.phase_pick : in_i.carry.phase_center;
    res_d.new_grain     = flip ? in_i.carry.grain_pick : in_i.carry.grain_center;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // Output valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule
`default_nettype wire

// ----- rtl/core/potts_metropolis_site_flip.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// potts_metropolis_site_flip: pipelined Metropolis trial for one Potts site
// Accepts one lattice site per transfer on the slave stream and returns one
// trial result per site on the master stream, in order.
//
// Channels: s_axis carries the site (concentration, phase bits, five grain
// ids, neighbour pick, uniform draw); m_axis carries new phase, new grain,
// flipped flag and the saturated energy change. The APB port holds the well
// weight, the two equilibrium compositions and the bond energy; write them
// only while no site is in flight.
//
// A site passes the site stage, the three energy stages and the accept stage,
// each registered, before its result is offered on m_axis. Throughput is
// one site per cycle while the receiver does not stall, since each of the five
// register stages takes a new item whenever its current one moves on; the two
// multiplier stages (composition product, then well weight) are the deepest.
//
// Reset clears every stage valid bit and loads the register defaults. When
// the receiver stalls, each stage holds its item and empty stages behind it
// still fill; s_axis_tready falls only once all five stages hold an item.
// ----------------------------------------------------------------------------
module potts_metropolis_site_flip (
  input  wire  logic                        clk_i,
  input  wire  logic                        rst_ni,
  // Site stream. tdata from bit 0: concentration[15:0], phase_bits[20:16],
  // center_grain[36:21], east_grain[52:37], west_grain[68:53],
  // north_grain[84:69], south_grain[100:85], neighbour_pick[102:101],
  // uniform_draw[118:103], zero[119].
  input  wire  logic                        s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  logic [pms_pkg::IN_W-1:0]    s_axis_tdata,
  // Result stream. tdata from bit 0: new_phase[0], new_grain[16:1],
  // flipped[17], energy_change[33:18], zero[39:34].
  output logic                              m_axis_tvalid,
  input  wire  logic                        m_axis_tready,
  output logic [pms_pkg::OUT_W-1:0]         m_axis_tdata,
  // Configuration port.
  input  wire  logic                        psel,
  input  wire  logic                        penable,
  input  wire  logic                        pwrite,
  input  wire  logic [pms_pkg::ADDR_W-1:0]  paddr,
  input  wire  logic [pms_pkg::DATA_W-1:0]  pwdata,
  output logic [pms_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  pms_pkg::cfg_t     cfg_q;
  pms_pkg::reg_idx_e reg_idx;
  logic              cfg_write;

  pms_pkg::site_t    site;
  logic              front_valid, front_ready;
  pms_pkg::front_t   front;
  logic              energy_valid, energy_ready;
  pms_pkg::energy_t  energy;
  pms_pkg::result_t  result;

  // Register file: written on the access cycle of an APB write.
  assign pready    = 1'b1;
  assign reg_idx   = pms_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.well_weight <= 15'd2048;
      cfg_q.alpha_comp  <= 13'd205;
      cfg_q.beta_comp   <= 13'd3891;
      cfg_q.bond_energy <= 15'd4096;
    end else if (cfg_write) begin
      unique case (reg_idx)
        pms_pkg::REG_WELL_WEIGHT: cfg_q.well_weight <= pwdata[pms_pkg::COEF_W-1:0];
        pms_pkg::REG_ALPHA_COMP:  cfg_q.alpha_comp  <= pwdata[pms_pkg::COMP_W-1:0];
        pms_pkg::REG_BETA_COMP:   cfg_q.beta_comp   <= pwdata[pms_pkg::COMP_W-1:0];
        pms_pkg::REG_BOND_ENERGY: cfg_q.bond_energy <= pwdata[pms_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      pms_pkg::REG_WELL_WEIGHT: prdata = 32'(cfg_q.well_weight);
      pms_pkg::REG_ALPHA_COMP:  prdata = 32'(cfg_q.alpha_comp);
      pms_pkg::REG_BETA_COMP:   prdata = 32'(cfg_q.beta_comp);
      pms_pkg::REG_BOND_ENERGY: prdata = 32'(cfg_q.bond_energy);
      default:                  prdata = '0;
    endcase
  end

  // Unpack the site fields.
  always_comb begin
    site.concentration  = s_axis_tdata[15:0];
    site.phase_bits     = s_axis_tdata[20:16];
    site.center_grain   = s_axis_tdata[21 +: pms_pkg::GRAIN_W];
    site.east_grain     = s_axis_tdata[37 +: pms_pkg::GRAIN_W];
    site.west_grain     = s_axis_tdata[53 +: pms_pkg::GRAIN_W];
    site.north_grain    = s_axis_tdata[69 +: pms_pkg::GRAIN_W];
    site.south_grain    = s_axis_tdata[85 +: pms_pkg::GRAIN_W];
    site.neighbour_pick = pms_pkg::pick_e'(s_axis_tdata[102:101]);
    site.uniform_draw   = s_axis_tdata[118:103];
  end

  pms_site_stage u_site (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .site_i      (site),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_o       (front)
  );

  pms_energy_pipe u_energy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_i        (front),
    .out_valid_o (energy_valid),
    .out_ready_i (energy_ready),
    .out_o       (energy)
  );

  pms_accept_stage u_accept (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (energy_valid),
    .in_ready_o  (energy_ready),
    .in_i        (energy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  // Pack the result fields.
  assign m_axis_tdata = {6'd0, result.energy_change, result.flipped,
                         16'(result.new_grain), result.new_phase};

  // A full pipeline is the only reason to refuse a site.
  a_stall_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready)
  ) else $error("input stalled while the output stage can drain");

  // A negative energy change must always be accepted.
  a_negative_flips: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[33]) |-> m_axis_tdata[17]
  ) else $error("negative energy change was not accepted");

  // A zero change hits the first table entry and is always accepted.
  a_zero_flips: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[33:18] == 16'd0)) |-> m_axis_tdata[17]
  ) else $error("zero energy change was not accepted");

  // A bond energy write lands in the register file.
  a_bond_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cfg_write && (reg_idx == pms_pkg::REG_BOND_ENERGY))
      |=> (cfg_q.bond_energy == $past(pwdata[pms_pkg::COEF_W-1:0]))
  ) else $error("bond energy register missed a write");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of potts_metropolis_site_flip
// A driver feeds lattice sites from a queue onto the slave stream while a
// monitor predicts each Metropolis trial at its input transfer and checks
// every result transfer against the oldest prediction. The run goes through
// several register settings, with random idling on both streams, one long
// receiver hold-off and sender pauses until the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int EXP_DEPTH      = pms_pkg::EXP_TABLE_DEPTH;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES   = 10;
  localparam int QUIET_LIMIT    = 4000;
  localparam int NUM_PHASES     = 6;

  // One lattice site as the testbench sees it.
  typedef struct {
    logic signed [15:0] concentration;
    logic [4:0]         phase_bits;
    logic [15:0]        center_grain;
    logic [15:0]        east_grain;
    logic [15:0]        west_grain;
    logic [15:0]        north_grain;
    logic [15:0]        south_grain;
    pms_pkg::pick_e     pick;
    logic [15:0]        draw;
  } lattice_site_t;

  // Outcome of one trial.
  typedef struct {
    logic               new_phase;
    logic [15:0]        new_grain;
    logic               flipped;
    logic signed [15:0] energy;
  } trial_t;

  // Register contents mirrored by the testbench.
  typedef struct {
    logic [14:0] well_weight;
    logic [12:0] alpha_comp;
    logic [12:0] beta_comp;
    logic [14:0] bond_energy;
  } energy_cfg_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [pms_pkg::IN_W-1:0]    s_axis_tdata  = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [pms_pkg::OUT_W-1:0]   m_axis_tdata;
  logic                        psel          = 1'b0;
  logic                        penable       = 1'b0;
  logic                        pwrite        = 1'b0;
  logic [pms_pkg::ADDR_W-1:0]  paddr         = '0;
  logic [pms_pkg::DATA_W-1:0]  pwdata        = '0;
  logic [pms_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  lattice_site_t pending_sites[$];
  trial_t        expected_trials[$];
  energy_cfg_t   active_cfg;
  int unsigned   exp_q16 [EXP_DEPTH];

  int          errors         = 0;
  int unsigned sites_accepted = 0;
  int unsigned offer_seq      = 0;
  int          quiet_cycles   = 0;
  int          tx_idle_pct    = 0;
  int          rx_idle_pct    = 0;
  int          rx_block_id    = 0;
  int          rx_block_seen  = 0;
  int          rx_block_left  = 0;

  potts_metropolis_site_flip dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Energy change of copying the picked neighbour onto the site, and the
  // Metropolis decision taken on the saturated value.
  function automatic trial_t predict_trial(lattice_site_t s);
    logic [15:0] grain [5];
    logic [4:0]  ph;
    int          sel;
    int          unlike_center;
    int          unlike_pick;
    int          dphi;
    int          idx;
    longint      c;
    longint      d_alpha;
    longint      d_beta;
    longint      well;
    longint      total;
    logic        take;
    trial_t      r;
    grain[0] = s.center_grain;
    grain[1] = s.east_grain;
    grain[2] = s.west_grain;
    grain[3] = s.north_grain;
    grain[4] = s.south_grain;
    ph  = s.phase_bits;
    sel = int'(s.pick) + 1;
    unlike_center = 0;
    unlike_pick   = 0;
    for (int k = 1; k < 5; k++) begin
      if (grain[k] != grain[0]) unlike_center++;
      if (grain[k] != grain[sel]) unlike_pick++;
    end
    c       = longint'(s.concentration);
    d_alpha = c - longint'(active_cfg.alpha_comp);
    d_beta  = c - longint'(active_cfg.beta_comp);
    // Q36 product rounded half up to Q12 by an arithmetic shift.
    well  = (longint'(active_cfg.well_weight) * (d_beta * d_beta - d_alpha * d_alpha)
             + (longint'(1) <<< 23)) >>> 24;
    dphi  = int'(ph[sel]) - int'(ph[0]);
    total = well * dphi
          + longint'(unlike_pick - unlike_center) * longint'(active_cfg.bond_energy);
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    if (total < 0) begin
      take = 1'b1;
    end else begin
      idx  = int'(total >>> 7);
      take = (idx < EXP_DEPTH) && (32'(s.draw) < exp_q16[idx]);
    end
    r.flipped   = take;
    r.new_phase = take ? ph[sel] : ph[0];
    r.new_grain = take ? grain[sel] : grain[0];
    r.energy    = 16'(total);
    return r;
  endfunction

  function automatic logic [pms_pkg::IN_W-1:0] pack_site(lattice_site_t s);
    return {1'b0, s.draw, s.pick, s.south_grain, s.north_grain, s.west_grain,
            s.east_grain, s.center_grain, s.phase_bits, s.concentration};
  endfunction

  function automatic lattice_site_t site_of(logic [15:0] conc, logic [4:0] phases,
                                            logic [15:0] gc, logic [15:0] ge,
                                            logic [15:0] gw, logic [15:0] gn,
                                            logic [15:0] gs, pms_pkg::pick_e pick,
                                            logic [15:0] draw);
    lattice_site_t s;
    s.concentration = conc;
    s.phase_bits    = phases;
    s.center_grain  = gc;
    s.east_grain    = ge;
    s.west_grain    = gw;
    s.north_grain   = gn;
    s.south_grain   = gs;
    s.pick          = pick;
    s.draw          = draw;
    return s;
  endfunction

  // Appends a site to the end of the pending queue.
  function automatic void queue_site(lattice_site_t s);
    pending_sites.insert(pending_sites.size(), s);
  endfunction

  // Grain ids mostly come from a small pool so that like and unlike
  // neighbours both occur often.
  function automatic logic [15:0] grain_from(logic [15:0] pool [3]);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return pool[$urandom_range(2)];
  endfunction

  function automatic lattice_site_t random_site();
    logic [15:0]   pool [3];
    logic [15:0]   conc;
    logic [15:0]   draw;
    lattice_site_t s;
    foreach (pool[k]) pool[k] = 16'($urandom);
    // Physical concentrations dominate; the rest spans the whole field.
    if ($urandom_range(9) < 7) conc = 16'($urandom_range(4096));
    else conc = 16'($urandom);
    case ($urandom_range(19))
      0:       draw = 16'h0000;
      1:       draw = 16'hFFFF;
      default: draw = 16'($urandom);
    endcase
    s = site_of(conc, 5'($urandom), grain_from(pool), grain_from(pool), grain_from(pool),
                grain_from(pool), grain_from(pool), pms_pkg::pick_e'($urandom_range(3)),
                draw);
    return s;
  endfunction

  // Sender: holds an offered site until its transfer, otherwise offers the
  // next pending site unless it idles this cycle.
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && sites_accepted == offer_seq)) begin
      if (pending_sites.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_site(pending_sites[0]);
        offer_seq     <= sites_accepted;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (rx_block_id != rx_block_seen) begin
      rx_block_seen <= rx_block_id;
      rx_block_left <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_block_left > 0) begin
      rx_block_left <= rx_block_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: predicts at each site transfer, checks at each result transfer
  // and ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    trial_t want;
    trial_t got;
    logic   moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_trials.insert(expected_trials.size(), predict_trial(pending_sites[0]));
        pending_sites.pop_front();
        sites_accepted++;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved         = 1'b1;
        got.new_phase = m_axis_tdata[0];
        got.new_grain = m_axis_tdata[16:1];
        got.flipped   = m_axis_tdata[17];
        got.energy    = m_axis_tdata[33:18];
        if (expected_trials.size() == 0) begin
          errors++;
          $display("%0t: result transfer with no site outstanding, data %h",
                   $time, m_axis_tdata);
        end else begin
          want = expected_trials.pop_front();
          if (got.new_phase !== want.new_phase) begin
            errors++;
            $display("%0t: new_phase expected %0d actual %0d",
                     $time, want.new_phase, got.new_phase);
          end
          if (got.new_grain !== want.new_grain) begin
            errors++;
            $display("%0t: new_grain expected %h actual %h",
                     $time, want.new_grain, got.new_grain);
          end
          if (got.flipped !== want.flipped) begin
            errors++;
            $display("%0t: flipped expected %0d actual %0d",
                     $time, want.flipped, got.flipped);
          end
          if (got.energy !== want.energy) begin
            errors++;
            $display("%0t: energy_change expected %0d actual %0d",
                     $time, want.energy, got.energy);
          end
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, expected_trials.size());
      $display("potts_metropolis_site_flip verification failed");
      $finish;
    end
  end

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic is_write, input pms_pkg::reg_idx_e idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = is_write;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_register(input pms_pkg::reg_idx_e idx, input logic [31:0] value);
    logic [31:0] rdata;
    apb_access(1'b0, idx, '0, rdata);
    if (rdata !== value) begin
      errors++;
      $display("%0t: register %s read expected %0d actual %0d",
               $time, idx.name(), value, rdata);
    end
  endtask

  // Writes a raw word; only the register's own bits are kept.
  task automatic set_register(input pms_pkg::reg_idx_e idx, input logic [31:0] raw);
    logic [31:0] rdata;
    logic [31:0] kept;
    apb_access(1'b1, idx, raw, rdata);
    case (idx)
      pms_pkg::REG_WELL_WEIGHT: begin
        active_cfg.well_weight = raw[14:0];
        kept = {17'd0, raw[14:0]};
      end
      pms_pkg::REG_ALPHA_COMP: begin
        active_cfg.alpha_comp = raw[12:0];
        kept = {19'd0, raw[12:0]};
      end
      pms_pkg::REG_BETA_COMP: begin
        active_cfg.beta_comp = raw[12:0];
        kept = {19'd0, raw[12:0]};
      end
      default: begin
        active_cfg.bond_energy = raw[14:0];
        kept = {17'd0, raw[14:0]};
      end
    endcase
    check_register(idx, kept);
  endtask

  task automatic wait_drained();
    while (pending_sites.size() != 0 || expected_trials.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [95:0] acc;
    logic [31:0] plan_cfg [NUM_PHASES][4];
    int          plan_items [NUM_PHASES];
    int          plan_tx [NUM_PHASES];
    int          plan_rx [NUM_PHASES];
    logic [15:0] ga;
    logic [15:0] gb;

    // exp(-i/32) in Q16 by repeated multiplication in Q32.
    acc = 96'd1 << 32;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      if (i > 0) acc = (acc * 96'(pms_pkg::EXP_STEP_Q32)) >> 32;
      exp_q16[i] = 32'((acc + 96'd32768) >> 16);
    end

    active_cfg.well_weight = 15'd2048;
    active_cfg.alpha_comp  = 13'd205;
    active_cfg.beta_comp   = 13'd3891;
    active_cfg.bond_energy = 15'd4096;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Register defaults after reset.
    check_register(pms_pkg::REG_WELL_WEIGHT, 32'd2048);
    check_register(pms_pkg::REG_ALPHA_COMP, 32'd205);
    check_register(pms_pkg::REG_BETA_COMP, 32'd3891);
    check_register(pms_pkg::REG_BOND_ENERGY, 32'd4096);
    wait_drained();

    // Directed sites under the reset settings.
    tx_idle_pct = 23;
    rx_idle_pct = 88;
    ga = 16'h1234;
    gb = 16'hEDCB;
    // Zero change always flips, even with the largest draw.
    queue_site(site_of(16'h0000, 5'b00000, ga, ga, ga, ga, ga,
                       pms_pkg::PICK_EAST, 16'hFFFF));
    queue_site(site_of(16'h7FFF, 5'b11111, ga, ga, ga, ga, ga,
                       pms_pkg::PICK_WEST, 16'hFFFF));
    // Two more unlike bonds: draw right at the table entry, then just below.
    queue_site(site_of(16'h0800, 5'b00000, ga, gb, ga, ga, ga,
                       pms_pkg::PICK_EAST, 16'(exp_q16[64])));
    queue_site(site_of(16'h0800, 5'b00000, ga, gb, ga, ga, ga,
                       pms_pkg::PICK_EAST, 16'(exp_q16[64] - 1)));
    // Negative change flips at once.
    queue_site(site_of(16'h0400, 5'b00000, ga, gb, gb, gb, gb,
                       pms_pkg::PICK_NORTH, 16'hFFFF));
    // Positive saturation lands on the last table entry.
    queue_site(site_of(16'h8000, 5'b00010, ga, gb, ga, ga, ga,
                       pms_pkg::PICK_EAST, 16'h0000));
    queue_site(site_of(16'h8000, 5'b00010, ga, gb, ga, ga, ga,
                       pms_pkg::PICK_EAST, 16'hFFFF));
    // Negative saturation.
    queue_site(site_of(16'h7FFF, 5'b00010, ga, gb, gb, gb, gb,
                       pms_pkg::PICK_EAST, 16'hFFFF));
    // Grain id extremes and assorted phase patterns for every pick.
    queue_site(site_of(16'h0000, 5'b10000, 16'h0000, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'hFFFF, pms_pkg::PICK_SOUTH, 16'h1000));
    queue_site(site_of(16'h0000, 5'b01001, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5,
                       pms_pkg::PICK_NORTH, 16'h8000));
    queue_site(site_of(16'hFFFF, 5'b00100, gb, ga, gb, ga, gb,
                       pms_pkg::PICK_WEST, 16'h4000));
    queue_site(site_of(16'h1000, 5'b10101, ga, gb, ga, gb, ga,
                       pms_pkg::PICK_SOUTH, 16'hC000));
    queue_site(site_of(16'd205, 5'b00001, ga, ga, gb, ga, gb,
                       pms_pkg::PICK_EAST, 16'h2000));
    queue_site(site_of(16'd3891, 5'b00110, gb, ga, ga, gb, ga,
                       pms_pkg::PICK_WEST, 16'h0001));
    queue_site(site_of(16'h8000, 5'b11110, 16'hFFFF, 16'h0000, 16'hFFFF,
                       16'h0000, 16'hFFFF, pms_pkg::PICK_WEST, 16'hFFFE));
    wait_drained();

    // Register settings per phase: well weight, alpha, beta, bond energy.
    plan_cfg[0] = '{32'($urandom_range(32767)), 32'($urandom_range(4096)),
                    32'($urandom_range(4096)), 32'($urandom_range(8192))};
    plan_cfg[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    plan_cfg[2] = '{32'd0, 32'd0, 32'd0, 32'd0};
    plan_cfg[3] = '{32'd2048, 32'd205, 32'd3891, 32'd4096};
    plan_cfg[4] = '{32'd32767, 32'd0, 32'd4096, 32'd1};
    plan_cfg[5] = '{32'($urandom_range(32767)), 32'($urandom_range(8191)),
                    32'($urandom_range(8191)), 32'($urandom_range(32767))};
    plan_items = '{200, 200, 100, 300, 200, 250};
    plan_tx    = '{23, 88, 88, 0, 0, 0};
    plan_rx    = '{88, 23, 23, 0, 0, 0};

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_register(pms_pkg::REG_WELL_WEIGHT, plan_cfg[p][0]);
      set_register(pms_pkg::REG_ALPHA_COMP, plan_cfg[p][1]);
      set_register(pms_pkg::REG_BETA_COMP, plan_cfg[p][2]);
      set_register(pms_pkg::REG_BOND_ENERGY, plan_cfg[p][3]);
      wait_drained();
      tx_idle_pct = plan_tx[p];
      rx_idle_pct = plan_rx[p];
      for (int i = 0; i < plan_items[p] / 2; i++) queue_site(random_site());
      // Long receiver hold-off while the sender keeps offering sites.
      if (p == 3) rx_block_id++;
      // The sender pauses until every result of the first half is back.
      wait_drained();
      for (int i = plan_items[p] / 2; i < plan_items[p]; i++) begin
        queue_site(random_site());
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("potts_metropolis_site_flip verification clean");
    end else begin
      $display("potts_metropolis_site_flip verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pms_pkg.sv
rtl/core/pms_site_stage.sv
rtl/core/pms_energy_pipe.sv
rtl/core/pms_accept_stage.sv
rtl/core/potts_metropolis_site_flip.sv
tb/tb_top.sv
